// ===== sv/ppa_pkg.sv =====
// ----------------------------------------------------------------------------
// ppa_pkg: shared constants for the polygon area and perimeter block
// Field widths of the result, saturation limits and default parameter values.
// ----------------------------------------------------------------------------
package ppa_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int AREA_BITS  = 42;
  localparam int LEN_BITS   = 35;
  localparam int CROSS_BITS = 44;

  localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0]  LEN_MAX  = {LEN_BITS{1'b1}};
  localparam logic signed [CROSS_BITS-1:0] CROSS_MAX = {1'b0, {(CROSS_BITS-1){1'b1}}};

  // vertex counter saturates here; a polygon needs this many vertices
  localparam logic [1:0] VERTEX_SAT = 2'd3;

endpackage

// ===== sv/polygon_area_perimeter.sv =====
// ----------------------------------------------------------------------------
// polygon_area_perimeter: shoelace area and perimeter of a polygon
// Streams vertices in, emits doubled area and perimeter per closed polygon.
// ----------------------------------------------------------------------------
// Vertices enter one per transaction; the one with last_vertex set closes the
// polygon, and one result transaction follows carrying twice the absolute area,
// the perimeter with FRAC_BITS fraction bits (each edge length truncated), a
// flag for at least three vertices and a saturation flag. The intake keeps the
// first and previous vertex and queues one edge job per vertex after the first,
// plus the closing edge, in a QUEUE_DEPTH-entry queue, so vertices are taken at
// one per cycle until the queue fills, stalling after a closing vertex while
// its second job is queued. Each edge passes through the edge unit's difference,
// multiply and prepare states, the bit-per-step square root of the squared edge
// length and the accumulate state; a closing edge adds an emit state. The edge
// unit takes a new edge job only as it finishes the one before it.
module polygon_area_perimeter import ppa_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  input  logic                         last_vertex,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [AREA_BITS-1:0]         area_doubled,
  output logic [LEN_BITS-1:0]          perimeter,
  output logic                         enough_vertices,
  output logic                         overflowed
);

  localparam int JOB_W = 4 * COORD_BITS + 2;

  logic             job_push, job_full, job_pop, job_valid;
  logic [JOB_W-1:0] job_in, job_out;

  ppa_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .last_vertex (last_vertex),
    .job_push    (job_push),
    .job_data    (job_in),
    .job_full    (job_full)
  );

  ppa_queue #(
    .W     (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_valid (job_valid),
    .pop_data  (job_out)
  );

  ppa_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (job_valid),
    .q_data          (job_out),
    .q_pop           (job_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .area_doubled    (area_doubled),
    .perimeter       (perimeter),
    .enough_vertices (enough_vertices),
    .overflowed      (overflowed)
  );

endmodule

// ===== sv/ppa_front.sv =====
// ----------------------------------------------------------------------------
// ppa_front: vertex intake
// Keeps the first and previous vertex and turns each vertex into edge jobs;
// the last vertex also yields the closing edge back to the first vertex.
// ----------------------------------------------------------------------------
module ppa_front import ppa_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int JOB_W      = 4 * COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  input  logic                         last_vertex,
  output logic                         job_push,
  output logic [JOB_W-1:0]             job_data,
  input  logic                         job_full
);

  // same layout as in ppa_back
  typedef struct packed {
    logic                         emit;
    logic                         enough;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
  } job_t;

  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic [1:0] vertex_count, vertex_count_next;
  logic       pend_valid;
  job_t       pend_job;
  job_t       job;
  logic       accept;
  logic       enough_next;

  assign in_stall          = pend_valid || job_full;
  assign accept            = in_valid && !in_stall;
  assign vertex_count_next = (vertex_count == VERTEX_SAT) ? vertex_count
                                                          : vertex_count + 2'd1;
  assign enough_next       = (vertex_count_next == VERTEX_SAT);

  always_comb begin
    job      = pend_job;
    job_push = 1'b0;
    if (pend_valid) begin
      job_push = !job_full;
    end else if (accept && (vertex_count != 2'd0 || last_vertex)) begin
      job_push = 1'b1;
      if (vertex_count == 2'd0) begin
        // lone vertex: closing edge runs to itself
        job = '{emit: 1'b1, enough: enough_next, ax: x_coord, ay: y_coord,
                bx: x_coord, by: y_coord};
      end else begin
        job = '{emit: 1'b0, enough: 1'b0, ax: prev_x, ay: prev_y,
                bx: x_coord, by: y_coord};
      end
    end
  end

  assign job_data = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 2'd0;
      pend_valid   <= 1'b0;
      first_x      <= '0;
      first_y      <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
    end else begin
      if (pend_valid && !job_full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        if (vertex_count == 2'd0) begin
          first_x <= x_coord;
          first_y <= y_coord;
        end
        prev_x       <= x_coord;
        prev_y       <= y_coord;
        vertex_count <= last_vertex ? 2'd0 : vertex_count_next;
        if (last_vertex && vertex_count != 2'd0) begin
          // hold the closing edge until the queue takes it
          pend_valid <= 1'b1;
          pend_job   <= '{emit: 1'b1, enough: enough_next, ax: x_coord, ay: y_coord,
                          bx: first_x, by: first_y};
        end
      end
    end
  end

endmodule

// ===== sv/ppa_queue.sv =====
// ----------------------------------------------------------------------------
// ppa_queue: edge job queue
// Small first-in first-out buffer between the vertex intake and the edge unit.
// ----------------------------------------------------------------------------
module ppa_queue import ppa_pkg::*; #(
  parameter int W     = 4 * COORD_BITS_DEF + 2,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("ppa_queue: push into full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("ppa_queue: pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("ppa_queue: fill count lost a push");

endmodule

// ===== sv/ppa_back.sv =====
// ----------------------------------------------------------------------------
// ppa_back: edge unit
// Per edge: cross product into the shoelace sum, squared length through a
// restoring square root, length into the perimeter sum; emits on closing edge.
// ----------------------------------------------------------------------------
module ppa_back import ppa_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int JOB_W      = 4 * COORD_BITS + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  logic [JOB_W-1:0]     q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [AREA_BITS-1:0] area_doubled,
  output logic [LEN_BITS-1:0]  perimeter,
  output logic                 enough_vertices,
  output logic                 overflowed
);

  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * COORD_BITS;
  localparam int RW    = PW + 1;
  localparam int NIT   = COORD_BITS + 2 + FRAC_BITS;
  localparam int RADW  = 2 * NIT;
  localparam int ITW   = $clog2(NIT);
  localparam int SUMW  = ((CROSS_BITS > PW + 1) ? CROSS_BITS : PW + 1) + 1;
  localparam int LSUMW = ((LEN_BITS > NIT) ? LEN_BITS : NIT) + 1;

  typedef struct packed {
    logic                         emit;
    logic                         enough;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
  } job_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIFF = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_PREP = 7'b0001000,
    S_ROOT = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state, state_next;
  job_t   job;

  logic [COORD_BITS-1:0]        mag_x, mag_y;
  logic signed [PW-1:0]         prod_ab, prod_ba;
  logic [PW-1:0]                sq_x, sq_y;
  logic signed [CROSS_BITS-1:0] cross_sum;
  logic [LEN_BITS-1:0]          length_sum;
  logic                         sat_flag;
  logic [RADW-1:0]              rad;
  logic [NIT-1:0]               root;
  logic [NIT:0]                 rem;
  logic [ITW-1:0]               iter;

  logic signed [DW-1:0]   dx, dy;
  logic signed [SUMW-1:0] cross_next;
  logic [RW-1:0]          r_sum;
  logic [NIT+2:0]         rem_sh, trial, rem_diff;
  logic                   take_bit;
  logic [LSUMW-1:0]       len_next;
  logic [CROSS_BITS-1:0]  area_mag;
  logic                   area_big;
  logic                   out_free;

  localparam logic signed [SUMW-1:0] CMAX_W = SUMW'(CROSS_MAX);

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    dx         = DW'(job.bx) - DW'(job.ax);
    dy         = DW'(job.by) - DW'(job.ay);
    cross_next = SUMW'(cross_sum) + SUMW'(prod_ab) - SUMW'(prod_ba);
    r_sum      = RW'(sq_x) + RW'(sq_y);
    rem_sh     = {rem, rad[RADW-1 -: 2]};
    trial      = {1'b0, root, 2'b01};
    rem_diff   = rem_sh - trial;
    take_bit   = (rem_sh >= trial);
    len_next   = LSUMW'(length_sum) + LSUMW'(root);
    area_mag   = cross_sum[CROSS_BITS-1] ? CROSS_BITS'(-cross_sum)
                                         : CROSS_BITS'(cross_sum);
    area_big   = (area_mag > CROSS_BITS'(AREA_MAX));
  end

  always_comb begin
    q_pop      = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        q_pop = q_valid;
      end
      S_DIFF: state_next = S_MUL;
      S_MUL:  state_next = S_PREP;
      S_PREP: state_next = S_ROOT;
      S_ROOT: begin
        if (iter == '0) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        if (job.emit) begin
          state_next = S_EMIT;
        end else begin
          q_pop      = q_valid;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          q_pop      = q_valid;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (q_pop) begin
      state_next = S_DIFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      cross_sum  <= '0;
      length_sum <= '0;
      sat_flag   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        job <= q_data;
      end
      unique case (state)
        S_DIFF: begin
          mag_x <= dx[DW-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
          mag_y <= dy[DW-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
        end
        S_MUL: begin
          prod_ab <= job.ax * job.by;
          prod_ba <= job.bx * job.ay;
          sq_x    <= mag_x * mag_x;
          sq_y    <= mag_y * mag_y;
        end
        S_PREP: begin
          if (cross_next > CMAX_W) begin
            cross_sum <= CROSS_MAX;
            sat_flag  <= 1'b1;
          end else if (cross_next < -CMAX_W) begin
            cross_sum <= -CROSS_MAX;
            sat_flag  <= 1'b1;
          end else begin
            cross_sum <= CROSS_BITS'(cross_next);
          end
          rad  <= RADW'(r_sum) << (2 * FRAC_BITS);
          root <= '0;
          rem  <= '0;
          iter <= ITW'(NIT - 1);
        end
        S_ROOT: begin
          rem  <= take_bit ? rem_diff[NIT:0] : rem_sh[NIT:0];
          root <= {root[NIT-2:0], take_bit};
          rad  <= rad << 2;
          iter <= iter - 1'b1;
        end
        S_ACC: begin
          if (len_next > LSUMW'(LEN_MAX)) begin
            length_sum <= LEN_MAX;
            sat_flag   <= 1'b1;
          end else begin
            length_sum <= LEN_BITS'(len_next);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            area_doubled    <= area_big ? AREA_MAX : area_mag[AREA_BITS-1:0];
            perimeter       <= length_sum;
            enough_vertices <= job.enough;
            overflowed      <= sat_flag || area_big;
            // start the next polygon from clean sums
            cross_sum       <= '0;
            length_sum      <= '0;
            sat_flag        <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_cross_clamped: assert property (@(posedge clk) disable iff (rst)
    cross_sum <= CROSS_MAX && cross_sum >= -CROSS_MAX)
    else $error("ppa_back: shoelace sum outside clamp range");
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_ROOT |-> rem <= {root, 1'b0})
    else $error("ppa_back: square root remainder out of bound");
  a_pop_only_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && (state == S_IDLE || state == S_ACC || state == S_EMIT))
    else $error("ppa_back: job taken while edge unit busy");

endmodule

// ===== bench/polygon_area_perimeter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polygon_area_perimeter_tb: self-checking bench for the shoelace block
// Streams polygons of varied size and shape into the block. A tracker keeps
// its own shoelace and edge-length sums, predicts one result per closed
// polygon, and compares each result transaction field by field. Runs through
// directed shapes, long windings of full-range corners, a long receiver
// hold-off, and random polygons under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module polygon_area_perimeter_tb;
  import ppa_pkg::*;

  localparam int CW            = COORD_BITS_DEF;
  localparam int FW            = FRAC_BITS_DEF;
  localparam int ROOT_STEPS    = CW + 2 + FW;
  localparam int HOLD_CYCLES   = 800;
  localparam int SETTLE_CYCLES = 150;
  localparam int PRINT_CAP     = 40;

  localparam longint          CROSS_LIM = CROSS_MAX;
  localparam longint unsigned AREA_LIM  = AREA_MAX;
  localparam longint unsigned LEN_LIM   = LEN_MAX;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};

  typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_CORNER} spread_e;

  typedef struct packed {
    logic [AREA_BITS-1:0] area;
    logic [LEN_BITS-1:0]  perim;
    logic                 enough;
    logic                 ovf;
  } polygon_result_t;

  class shoelace_tracker;
    longint          first_x, first_y, prev_x, prev_y;
    longint          cross_acc;
    longint unsigned length_acc;
    logic [1:0]      vertex_count;
    bit              sat_seen;
    polygon_result_t pending_polygons[$];
    int              mismatches;

    function new();
      mismatches = 0;
      clear_polygon();
    endfunction

    function void clear_polygon();
      first_x = 0;
      first_y = 0;
      prev_x = 0;
      prev_y = 0;
      cross_acc = 0;
      length_acc = 0;
      vertex_count = '0;
      sat_seen = 0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("MISMATCH %0t: %s", $time, msg);
    endtask

    // floor(sqrt(sq)) with FW fraction bits, two radicand bits per step
    function longint unsigned edge_length_q8(longint unsigned sq);
      longint unsigned root, rem, trial, pair;
      root = 0;
      rem = 0;
      for (int i = ROOT_STEPS - 1; i >= 0; i--) begin
        pair = (i >= FW) ? ((sq >> (2 * (i - FW))) & 64'd3) : 64'd0;
        rem = (rem << 2) | pair;
        trial = (root << 2) | 64'd1;
        if (rem >= trial) begin
          rem -= trial;
          root = (root << 1) | 64'd1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    function void trace_edge(longint ax, longint ay, longint bx, longint by);
      longint unsigned dx, dy;
      cross_acc += ax * by - bx * ay;
      if (cross_acc > CROSS_LIM) begin
        cross_acc = CROSS_LIM;
        sat_seen = 1;
      end else if (cross_acc < -CROSS_LIM) begin
        cross_acc = -CROSS_LIM;
        sat_seen = 1;
      end
      dx = (bx > ax) ? bx - ax : ax - bx;
      dy = (by > ay) ? by - ay : ay - by;
      length_acc += edge_length_q8(dx * dx + dy * dy);
      if (length_acc > LEN_LIM) begin
        length_acc = LEN_LIM;
        sat_seen = 1;
      end
    endfunction

    function void take_vertex(coord_t x, coord_t y, logic lst);
      longint          xs, ys;
      longint unsigned area;
      polygon_result_t r;
      xs = x;
      ys = y;
      if (vertex_count == 0) begin
        first_x = xs;
        first_y = ys;
      end else begin
        trace_edge(prev_x, prev_y, xs, ys);
      end
      prev_x = xs;
      prev_y = ys;
      if (vertex_count != VERTEX_SAT)
        vertex_count++;
      if (lst) begin
        // close the ring back to the first vertex
        trace_edge(xs, ys, first_x, first_y);
        area = (cross_acc < 0) ? -cross_acc : cross_acc;
        r.ovf = sat_seen;
        if (area > AREA_LIM) begin
          area = AREA_LIM;
          r.ovf = 1'b1;
        end
        r.area = area[AREA_BITS-1:0];
        r.perim = length_acc[LEN_BITS-1:0];
        r.enough = (vertex_count == VERTEX_SAT);
        pending_polygons = {pending_polygons, r};
        clear_polygon();
      end
    endfunction

    task check_polygon(logic [AREA_BITS-1:0] area, logic [LEN_BITS-1:0] perim,
                       logic enough, logic ovf);
      polygon_result_t want;
      if (pending_polygons.size() == 0) begin
        report($sformatf("result with no polygon pending: area %0d perimeter %0d",
                         area, perim));
        return;
      end
      want = pending_polygons.pop_front();
      if (area !== want.area)
        report($sformatf("area_doubled %0d, predicted %0d", area, want.area));
      if (perim !== want.perim)
        report($sformatf("perimeter %0d, predicted %0d", perim, want.perim));
      if (enough !== want.enough)
        report($sformatf("enough_vertices %b, predicted %b", enough, want.enough));
      if (ovf !== want.ovf)
        report($sformatf("overflowed %b, predicted %b", ovf, want.ovf));
    endtask
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  coord_t               x_coord = '0;
  coord_t               y_coord = '0;
  logic                 last_vertex = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [AREA_BITS-1:0] area_doubled;
  logic [LEN_BITS-1:0]  perimeter;
  logic                 enough_vertices;
  logic                 overflowed;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;

  shoelace_tracker board;

  polygon_area_perimeter uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .x_coord         (x_coord),
    .y_coord         (y_coord),
    .last_vertex     (last_vertex),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .area_doubled    (area_doubled),
    .perimeter       (perimeter),
    .enough_vertices (enough_vertices),
    .overflowed      (overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= (rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      board.check_polygon(area_doubled, perimeter, enough_vertices, overflowed);
  end

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // keep valid high across back-to-back transactions; drop it only to idle
  task automatic send_vertex(input coord_t x, input coord_t y, input logic lst);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    x_coord <= x;
    y_coord <= y;
    last_vertex <= lst;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.take_vertex(x, y, lst);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (board.pending_polygons.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t pick_coord(spread_e s);
    case (s)
      SPREAD_FULL: return coord_t'($urandom);
      SPREAD_NEAR: return coord_t'(int'($urandom_range(256)) - 128);
      default: begin
        case ($urandom_range(4))
          0: return C_MIN;
          1: return C_MAX;
          2: return coord_t'(0);
          3: return coord_t'(-1);
          default: return coord_t'(1);
        endcase
      end
    endcase
  endfunction

  function automatic int pick_size();
    int roll = $urandom_range(99);
    if (roll < 60)
      return $urandom_range(1, 5);
    if (roll < 90)
      return $urandom_range(6, 16);
    return $urandom_range(17, 40);
  endfunction

  task automatic run_directed();
    // lone vertex: closing edge is degenerate
    send_vertex(C_MIN, C_MAX, 1'b1);
    // two vertices: longest edge, walked both ways
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b1);
    send_vertex(coord_t'(0), coord_t'(0), 1'b0);
    send_vertex(C_MAX, coord_t'(0), 1'b0);
    send_vertex(coord_t'(0), C_MAX, 1'b1);
    // full-range square, counterclockwise then clockwise
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b0);
    send_vertex(C_MIN, C_MAX, 1'b1);
    send_vertex(C_MIN, C_MAX, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b0);
    send_vertex(C_MIN, C_MIN, 1'b1);
    // all vertices at the origin
    send_vertex(coord_t'(0), coord_t'(0), 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), 1'b1);
    // collinear
    send_vertex(coord_t'(-5), coord_t'(-5), 1'b0);
    send_vertex(coord_t'(0), coord_t'(0), 1'b0);
    send_vertex(coord_t'(7), coord_t'(7), 1'b1);
    // diamond on the axes
    send_vertex(C_MIN, coord_t'(0), 1'b0);
    send_vertex(coord_t'(0), C_MIN, 1'b0);
    send_vertex(C_MAX, coord_t'(0), 1'b0);
    send_vertex(coord_t'(0), C_MAX, 1'b1);
  endtask

  // wind the full-range square many times; the cross sum grows every lap
  task automatic wind_square(input int laps, input bit ccw);
    coord_t cx[4] = '{C_MIN, C_MAX, C_MAX, C_MIN};
    coord_t cy[4] = '{C_MIN, C_MIN, C_MAX, C_MAX};
    int idx;
    for (int lap = 0; lap < laps; lap++) begin
      for (int c = 0; c < 4; c++) begin
        idx = ccw ? c : 3 - c;
        send_vertex(cx[idx], cy[idx], lap == laps - 1 && c == 3);
      end
    end
  endtask

  // bounce between opposite corners: long edges, cross terms cancel
  task automatic zigzag(input int count);
    for (int k = 0; k < count; k++) begin
      if (k % 2 == 0)
        send_vertex(C_MIN, C_MIN, k == count - 1);
      else
        send_vertex(C_MAX, C_MAX, k == count - 1);
    end
  endtask

  task automatic run_random(input int target);
    int      sent = 0;
    int      n;
    spread_e s;
    while (sent < target) begin
      n = pick_size();
      s = spread_e'($urandom_range(2));
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(4) == 0)
          send_vertex(pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL), k == n - 1);
        else
          send_vertex(pick_coord(s), pick_coord(s), k == n - 1);
      end
      sent += n;
    end
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_idling(0, 0);
    run_directed();
    wait_all_results();

    // long windings in both directions, then a long zigzag
    set_idling(16, 16);
    wind_square(20, 1'b1);
    wind_square(10, 1'b0);
    zigzag(40);
    wait_all_results();

    // long receiver hold-off while the sender keeps offering triangles
    set_idling(0, 0);
    hold_requests <= hold_requests + 1;
    for (int t = 0; t < 40; t++) begin
      send_vertex(pick_coord(SPREAD_NEAR), pick_coord(SPREAD_NEAR), 1'b0);
      send_vertex(pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL), 1'b0);
      send_vertex(pick_coord(SPREAD_NEAR), pick_coord(SPREAD_NEAR), 1'b1);
    end
    wait_all_results();

    set_idling(0, 0);
    run_random(90);
    wait_all_results();
    set_idling(77, 0);
    run_random(90);
    wait_all_results();
    set_idling(0, 77);
    run_random(90);
    wait_all_results();
    set_idling(16, 16);
    run_random(90);
    wait_all_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending_polygons.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== polygon_area_perimeter.f =====
sv/ppa_pkg.sv
sv/ppa_front.sv
sv/ppa_queue.sv
sv/ppa_back.sv
sv/polygon_area_perimeter.sv
bench/polygon_area_perimeter_tb.sv
